FILE: rtl/core/pse_pkg.sv
// Shared types and constants for the projection set enumerator.
// Used by pse_ctrl, pse_datapath and projection_set_enumerator. No dependencies.
`timescale 1ns / 1ps

package pse_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int COORD_BITS_DEF = 6;

  localparam int DIM_W      = 4;
  localparam int SEQ_W      = 7;
  localparam int POS_W      = 6;
  localparam int OUT_C_W    = 6;
  localparam int LIM_W      = 6;
  localparam int SUM_W      = 10;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int SEQ_MAX    = 64;
  localparam int MIN_DIM_MAX = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_LIMITS = 2'd2;

  localparam logic REQ_ADVANCE = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef struct packed {
    logic restart;
    logic adv;
    logic first;
    logic grow;
    logic new_dim;
    logic bump2;
    logic init_wr;
    logic bump_wr;
    logic chain;
    logic set_size;
    logic idx_clr;
    logic idx_top;
    logic idx_inc;
    logic idx_dec;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic exhaust;
    logic cd_zero;
    logic at_end;
    logic cd_one;
    logic size_zero;
    logic cd_two;
    logic scan_stop;
    logic idx_last;
    logic emit_last;
  } dp_status_t;

endpackage

FILE: rtl/core/projection_set_enumerator.sv
// Projection set enumerator: one coordinate result per cycle while a set is emitted,
// out_valid strobed, no stall. A restart request gives no results. An advance request is
// accepted, then a new set of dimension d is built or the current one is scanned and
// refilled, then n results follow; short paths go from accept straight to emit.
// The coordinate file's single write port sets the build and scan lengths.
// Reset (rst_n, synchronous): config back to defaults, enumeration back to its start.
`timescale 1ns / 1ps

module projection_set_enumerator #(
  parameter int MAX_DIM    = pse_pkg::MAX_DIM_DEF,
  parameter int COORD_BITS = pse_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [pse_pkg::DIM_W-1:0]      in_restart_dim,
  output logic                           out_valid,
  output logic [pse_pkg::OUT_C_W-1:0]    out_coordinate,
  output logic [pse_pkg::POS_W-1:0]      out_position,
  output logic [pse_pkg::SEQ_W-1:0]      out_proj_size,
  output logic                           out_exhausted,
  output logic                           out_last
);
  import pse_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  pse_datapath #(
    .MAX_DIM    (MAX_DIM),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .restart_dim    (in_restart_dim),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_coordinate (out_coordinate),
    .out_position   (out_position),
    .out_proj_size  (out_proj_size),
    .out_exhausted  (out_exhausted),
    .out_last       (out_last)
  );

endmodule

FILE: rtl/core/pse_ctrl.sv
// Controller FSM of the projection set enumerator.
// Depends on pse_pkg; drives pse_datapath through ctl_cmd_t, reads dp_status_t.
`timescale 1ns / 1ps

module pse_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 req_type,
  input  pse_pkg::dp_status_t  status,
  output pse_pkg::ctl_cmd_t    cmd,
  output logic                 busy
);
  import pse_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INIT = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_FILL = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (req_type == REQ_RESTART) begin
            cmd.restart = 1'b1;
          end else begin
            cmd.adv = 1'b1;
            priority if (status.exhaust) begin
              cmd.idx_clr = 1'b1;
              state_nxt   = ST_EMIT;
            end else if (status.cd_zero) begin
              cmd.first   = 1'b1;
              cmd.idx_clr = 1'b1;
              state_nxt   = ST_EMIT;
            end else if (status.at_end) begin
              cmd.new_dim = 1'b1;
              cmd.idx_clr = 1'b1;
              state_nxt   = ST_INIT;
            end else if (status.cd_one) begin
              cmd.grow    = 1'b1;
              cmd.idx_clr = 1'b1;
              state_nxt   = ST_EMIT;
            end else if (status.size_zero) begin
              cmd.idx_clr = 1'b1;
              state_nxt   = ST_INIT;
            end else if (status.cd_two) begin
              cmd.bump2   = 1'b1;
              cmd.idx_clr = 1'b1;
              state_nxt   = ST_EMIT;
            end else begin
              cmd.idx_top = 1'b1;
              state_nxt   = ST_SCAN;
            end
          end
        end
      end
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (status.idx_last) begin
          cmd.set_size = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_SCAN: begin
        if (status.scan_stop) begin
          cmd.bump_wr = 1'b1;
          if (status.idx_last) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = ST_EMIT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_FILL;
          end
        end else begin
          cmd.idx_dec = 1'b1;
        end
      end
      ST_FILL: begin
        cmd.bump_wr = 1'b1;
        cmd.chain   = 1'b1;
        if (status.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.idx_inc = 1'b1;
        if (status.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/pse_datapath.sv
// Datapath of the projection set enumerator: config registers, set state,
// coordinate register file, limit compares and result registers. Uses pse_pkg.
`timescale 1ns / 1ps

module pse_datapath #(
  parameter int MAX_DIM    = pse_pkg::MAX_DIM_DEF,
  parameter int COORD_BITS = pse_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [pse_pkg::DIM_W-1:0]         restart_dim,
  input  pse_pkg::ctl_cmd_t                 cmd,
  output pse_pkg::dp_status_t               status,
  output logic                              out_valid,
  output logic [pse_pkg::OUT_C_W-1:0]       out_coordinate,
  output logic [pse_pkg::POS_W-1:0]         out_position,
  output logic [pse_pkg::SEQ_W-1:0]         out_proj_size,
  output logic                              out_exhausted,
  output logic                              out_last
);
  import pse_pkg::*;

  localparam int IW      = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int CMAX    = (1 << COORD_BITS) - 1;
  localparam int LIM_CAP = (CMAX < 63) ? CMAX : 63;
  localparam logic [SUM_W-1:0] CAP_S = SUM_W'(LIM_CAP);

  function automatic logic [COORD_BITS-1:0] sat(input logic [SUM_W-1:0] v);
    if (v > CAP_S) begin
      sat = COORD_BITS'(LIM_CAP);
    end else begin
      sat = v[COORD_BITS-1:0];
    end
  endfunction

  logic [DIM_W-1:0]      num_dims_r;
  logic [SEQ_W-1:0]      min_dim_r;
  logic [CFG_DATA_W-1:0] dim_limits_r;
  logic [DIM_W-1:0]      cd_r;
  logic [SEQ_W-1:0]      seq_r;
  logic [DIM_W-1:0]      size_r;
  logic [POS_W-1:0]      idx_r;
  logic                  ex_r;
  logic [COORD_BITS-1:0] prev_r;
  logic [COORD_BITS-1:0] coords_r [MAX_DIM];
  logic                  out_valid_r;
  logic [OUT_C_W-1:0]    out_coord_r;
  logic [POS_W-1:0]      out_pos_r;
  logic [SEQ_W-1:0]      out_size_r;
  logic                  out_ex_r;
  logic                  out_last_r;

  logic [DIM_W-1:0]      eff_dims;
  logic [SEQ_W-1:0]      min_cl;
  logic [LIM_W-1:0]      fl;
  logic [2:0]            lim_sel;
  logic [7:0]            lim_byte;
  logic [LIM_W-1:0]      lim;
  logic [SEQ_W-1:0]      cur_size;
  logic [COORD_BITS-1:0] c1;
  logic [COORD_BITS-1:0] rd;
  logic [DIM_W-1:0]      cd_m1;
  logic                  at_end;
  logic [SUM_W-1:0]      rd_ext;
  logic [SUM_W-1:0]      init_base;
  logic [COORD_BITS-1:0] bump_val;
  logic [COORD_BITS-1:0] wr_val;
  logic [IW-1:0]         wr_idx;
  logic                  wr_en;

  assign eff_dims = (num_dims_r == '0) ? DIM_W'(1) :
                    (num_dims_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : num_dims_r;
  assign min_cl   = (min_dim_r == '0) ? SEQ_W'(1) :
                    (min_dim_r > SEQ_W'(MIN_DIM_MAX)) ? SEQ_W'(MIN_DIM_MAX) : min_dim_r;
  assign fl       = LIM_W'(min_cl - SEQ_W'(1));

  assign cd_m1    = cd_r - DIM_W'(1);
  assign lim_sel  = cd_m1[2:0];
  assign lim_byte = dim_limits_r[{lim_sel, 3'b000} +: 8];
  assign lim      = (lim_byte > 8'(LIM_CAP)) ? LIM_W'(LIM_CAP) : lim_byte[LIM_W-1:0];

  assign cur_size = (cd_r == DIM_W'(1)) ? seq_r : SEQ_W'(size_r);
  assign c1       = coords_r[1];
  assign rd       = coords_r[idx_r[IW-1:0]];
  assign rd_ext   = SUM_W'(rd);

  always_comb begin
    if (cd_r == '0 || cur_size == '0) begin
      at_end = 1'b0;
    end else if (cd_r == DIM_W'(1)) begin
      at_end = SUM_W'(seq_r) >= SUM_W'(lim) + SUM_W'(1);
    end else if (cd_r == DIM_W'(2)) begin
      at_end = SUM_W'(c1) >= SUM_W'(lim);
    end else begin
      at_end = SUM_W'(c1) + SUM_W'(cd_r) >= SUM_W'(lim) + SUM_W'(2);
    end
  end

  assign status.at_end    = at_end;
  assign status.exhaust   = at_end && (cd_r >= eff_dims);
  assign status.cd_zero   = (cd_r == '0);
  assign status.cd_one    = (cd_r == DIM_W'(1));
  assign status.cd_two    = (cd_r == DIM_W'(2));
  assign status.size_zero = (size_r == '0);
  assign status.idx_last  = (idx_r == POS_W'(cd_m1));
  assign status.emit_last = (SEQ_W'(idx_r) + SEQ_W'(1) == cur_size);
  assign status.scan_stop = (idx_r == '0) ||
    !(rd_ext + SUM_W'(cd_r) >= SUM_W'(lim) + SUM_W'(idx_r) + SUM_W'(1));

  // last coordinate of a fresh set starts at max(d, floor)
  assign init_base = (status.idx_last) ?
                     ((SUM_W'(cd_r) > SUM_W'(fl)) ? SUM_W'(cd_r) : SUM_W'(fl)) :
                     SUM_W'(idx_r);

  always_comb begin
    bump_val = sat((cmd.chain ? SUM_W'(prev_r) : rd_ext) + SUM_W'(1));
    priority if (cmd.bump2) begin
      wr_idx = IW'(1);
      wr_val = sat(SUM_W'(c1) + SUM_W'(1));
    end else if (cmd.init_wr) begin
      wr_idx = idx_r[IW-1:0];
      wr_val = sat(init_base);
    end else begin
      wr_idx = idx_r[IW-1:0];
      if (status.idx_last && SUM_W'(bump_val) < SUM_W'(fl)) begin
        wr_val = sat(SUM_W'(fl));
      end else begin
        wr_val = bump_val;
      end
    end
  end

  assign wr_en = cmd.bump2 | cmd.init_wr | cmd.bump_wr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      coords_r[wr_idx] <= wr_val;
    end
    if (cmd.bump_wr) begin
      prev_r <= bump_val;
    end
    if (cmd.adv) begin
      ex_r <= status.exhaust;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r   <= DIM_W'(1);
      min_dim_r    <= SEQ_W'(1);
      dim_limits_r <= '0;
      cd_r         <= '0;
      seq_r        <= '0;
      size_r       <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_DIMS:   num_dims_r   <= cfg_data[DIM_W-1:0];
          CFG_MIN_DIM:    min_dim_r    <= cfg_data[SEQ_W-1:0];
          CFG_DIM_LIMITS: dim_limits_r <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.restart && restart_dim <= eff_dims) begin
        cd_r   <= restart_dim;
        seq_r  <= '0;
        size_r <= '0;
      end
      if (cmd.first) begin
        seq_r <= SEQ_W'(fl) + SEQ_W'(1);
        cd_r  <= DIM_W'(1);
      end
      if (cmd.grow && seq_r < SEQ_W'(SEQ_MAX)) begin
        seq_r <= seq_r + SEQ_W'(1);
      end
      if (cmd.new_dim) begin
        cd_r   <= cd_r + DIM_W'(1);
        seq_r  <= '0;
        size_r <= '0;
      end
      if (cmd.set_size) begin
        size_r <= cd_r;
      end

      priority if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_top) begin
        idx_r <= POS_W'(cd_m1);
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + POS_W'(1);
      end else if (cmd.idx_dec) begin
        idx_r <= idx_r - POS_W'(1);
      end else begin
        idx_r <= idx_r;
      end

      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_coord_r <= (cd_r == DIM_W'(1)) ? OUT_C_W'(idx_r) : rd_ext[OUT_C_W-1:0];
      out_pos_r   <= idx_r;
      out_size_r  <= cur_size;
      out_ex_r    <= ex_r;
      out_last_r  <= status.emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_coordinate = out_coord_r;
  assign out_position   = out_pos_r;
  assign out_proj_size  = out_size_r;
  assign out_exhausted  = out_ex_r;
  assign out_last       = out_last_r;

endmodule
